// ===== design/bbc_pkg.sv =====
package bbc_pkg;

   localparam int unsigned StatusWidth = 4;
   localparam int unsigned OpWidth     = 3;
   localparam int unsigned DeviceWidth = 16;
   localparam int unsigned BlockWidth  = 32;
   localparam int unsigned FlagWidth   = 8;

   typedef enum logic [OpWidth-1:0] {
      OP_GET_BLOCK = 3'd0,
      OP_GET_EMPTY = 3'd1,
      OP_RELEASE   = 3'd2,
      OP_START_RD  = 3'd3,
      OP_START_WR  = 3'd4,
      OP_IO_DONE   = 3'd5,
      OP_FLUSH     = 3'd6,
      OP_UNUSED    = 3'd7
   } op_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_HIT       = 4'd0,
      ST_ASSIGNED  = 4'd1,
      ST_WAIT_BUSY = 4'd2,
      ST_WAIT_FREE = 4'd3,
      ST_VICTIM    = 4'd4,
      ST_RELEASED  = 4'd5,
      ST_RD_START  = 4'd6,
      ST_WR_START  = 4'd7,
      ST_DONE      = 4'd8,
      ST_FLUSHED   = 4'd9,
      ST_NO_FLUSH  = 4'd10,
      ST_BAD       = 4'd11
   } status_type;

   localparam logic [FlagWidth-1:0] FL_BUSY   = 8'h01;
   localparam logic [FlagWidth-1:0] FL_WANTED = 8'h02;
   localparam logic [FlagWidth-1:0] FL_DONE   = 8'h04;
   localparam logic [FlagWidth-1:0] FL_DELWRI = 8'h08;
   localparam logic [FlagWidth-1:0] FL_ASYNC  = 8'h10;
   localparam logic [FlagWidth-1:0] FL_AGE    = 8'h20;
   localparam logic [FlagWidth-1:0] FL_ERROR  = 8'h40;
   localparam logic [FlagWidth-1:0] FL_READ   = 8'h80;

   localparam logic [1:0] REG_DEV_COUNT = 2'd0;
   localparam logic [1:0] REG_TAPE_MASK = 2'd1;

   function automatic logic [FlagWidth-1:0] write_flags(logic [FlagWidth-1:0] f,
                                                         logic async_in);
      logic [FlagWidth-1:0] old;
      logic [FlagWidth-1:0] nf;
      old = async_in ? (f | FL_ASYNC) : f;
      nf  = old & ~(FL_READ | FL_DONE | FL_ERROR | FL_DELWRI | FL_AGE);
      if (((old & FL_ASYNC) != '0) && ((old & FL_DELWRI) != '0)) begin
         nf = nf | FL_AGE;
      end
      return nf;
   endfunction

endpackage

// ===== design/bbc_req_if.sv =====
interface bbc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [15:0] device;
   logic [31:0] block_number;
   logic [3:0]  buffer_index;
   logic        all_devices;
   logic        delayed;
   logic        async;
   logic        io_error;
   modport source (output valid, operation, device, block_number, buffer_index,
                   all_devices, delayed, async, io_error, input ready);
   modport sink (input valid, operation, device, block_number, buffer_index,
                 all_devices, delayed, async, io_error, output ready);
endinterface

// ===== design/bbc_rsp_if.sv =====
interface bbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] status;
   logic [3:0] result_index;
   logic       data_valid;
   logic       wake_buffer;
   logic       wake_free;
   logic       had_error;
   modport source (output valid, status, result_index, data_valid, wake_buffer,
                   wake_free, had_error, input ready);
   modport sink (input valid, status, result_index, data_valid, wake_buffer,
                 wake_free, had_error, output ready);
endinterface

// ===== design/block_buffer_cache_controller.sv =====
// Block buffer cache directory with an LRU free list.
// req: one request item per handshake (get block, get empty, release,
//    start read/write, io done, flush next). rsp: one result item per request.
// csr: APB write/read of block_device_count (0x0) and tape_major_mask (0x4).
// Order of work, request handshake to result: get block scans the tag store one
//    entry per cycle through a single comparator; flush next walks the free
//    list from the head, reading each link's tag before testing it; other
//    requests go straight to execution.
//    The result then sits in the output register until taken.
// Flow: one request at a time; req.ready is low from acceptance until
//    the result has been taken, so a new request waits for the last result.
// Reset: flags and tag valid bits clear, free list 0..BUFFER_COUNT-1 with 0 at
//    the head, register reset values loaded. Tag memory is not cleared.
// Stall: a held result blocks the next request; nothing is dropped.
module block_buffer_cache_controller
   import bbc_pkg::*;
#(
   parameter int unsigned BUFFER_COUNT = 16,
   parameter int unsigned MAJOR_COUNT  = 8
) (
   input  logic        clock,
   input  logic        reset,
   bbc_req_if.sink     req,
   bbc_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned IW = $clog2(BUFFER_COUNT);
   localparam int unsigned LW = $clog2(BUFFER_COUNT + 1);
   localparam logic [LW-1:0] ANCHOR = LW'(BUFFER_COUNT);
   localparam logic [LW-1:0] LAST   = LW'(BUFFER_COUNT - 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_WALK  = 5'b00100,
      S_EXEC  = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [3:0] dev_count_ff, dev_count_in;
   logic [7:0] tape_mask_ff, tape_mask_in;

   logic [BUFFER_COUNT-1:0] assigned_ff, assigned_in;
   logic [FlagWidth-1:0] flags_ff [BUFFER_COUNT];
   logic [FlagWidth-1:0] flags_in [BUFFER_COUNT];
   logic [LW-1:0] next_ff [BUFFER_COUNT+1];
   logic [LW-1:0] next_in [BUFFER_COUNT+1];
   logic [LW-1:0] prev_ff [BUFFER_COUNT+1];
   logic [LW-1:0] prev_in [BUFFER_COUNT+1];
   logic free_wait_ff, free_wait_in;

   logic [DeviceWidth-1:0] tag_dev_mem [BUFFER_COUNT];
   logic [BlockWidth-1:0]  tag_blk_mem [BUFFER_COUNT];
   logic [DeviceWidth-1:0] rd_dev_ff;
   logic [BlockWidth-1:0]  rd_blk_ff;
   logic [IW-1:0] rd_addr;
   logic          tag_we;
   logic [IW-1:0] tag_waddr;
   logic [DeviceWidth-1:0] tag_wdev;
   logic [BlockWidth-1:0]  tag_wblk;

   logic [2:0]  op_ff, op_in;
   logic [15:0] dev_ff, dev_in;
   logic [31:0] blk_ff, blk_in;
   logic [3:0]  bi_ff, bi_in;
   logic all_ff, all_in, dly_ff, dly_in, asy_ff, asy_in, ioe_ff, ioe_in;

   logic [IW:0]   cnt_ff, cnt_in;
   logic [LW-1:0] cur_ff, cur_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;
   logic          hit_ff, hit_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;

   logic [3:0] st_ff, st_in;
   logic [3:0] idx_ff, idx_in;
   logic dv_ff, dv_in, wb_ff, wb_in, wf_ff, wf_in, er_ff, er_in;

   logic req_fire, rsp_fire, csr_wr, major_bad, cmp_match;
   logic [7:0] major;

   assign req_fire  = req.valid && req.ready;
   assign rsp_fire  = rsp.valid && rsp.ready;
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite;
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.status       = st_ff;
   assign rsp.result_index = idx_ff;
   assign rsp.data_valid   = dv_ff;
   assign rsp.wake_buffer  = wb_ff;
   assign rsp.wake_free    = wf_ff;
   assign rsp.had_error    = er_ff;
   assign csr_pready = 1'b1;
   assign major = dev_ff[15:8];
   assign major_bad = (major >= {4'd0, dev_count_ff}) || (major >= 8'(MAJOR_COUNT));
   assign cmp_match = cmp_vld_ff && assigned_ff[cmp_idx_ff] &&
                      (rd_dev_ff == dev_ff) && (rd_blk_ff == blk_ff);

   always_comb begin
      case (csr_paddr[2])
         1'b0:    csr_prdata = {28'd0, dev_count_ff};
         default: csr_prdata = {24'd0, tape_mask_ff};
      endcase
   end

   always_comb begin
      dev_count_in = dev_count_ff;
      tape_mask_in = tape_mask_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == REG_DEV_COUNT[0]) begin
            dev_count_in = csr_pwdata[3:0];
         end else begin
            tape_mask_in = csr_pwdata[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_dev_mem[tag_waddr] <= tag_wdev;
         tag_blk_mem[tag_waddr] <= tag_wblk;
      end
      rd_dev_ff <= tag_dev_mem[rd_addr];
      rd_blk_ff <= tag_blk_mem[rd_addr];
   end

   always_comb begin
      logic [IW-1:0] bi;
      logic [IW-1:0] h;
      logic [LW-1:0] p, n, t;
      logic [FlagWidth-1:0] f;
      logic tape;
      logic rel;
      logic claim;
      logic [IW-1:0] ci;
      logic [7:0] emaj;
      state_in = state_ff;
      assigned_in = assigned_ff;
      flags_in = flags_ff;
      next_in = next_ff;
      prev_in = prev_ff;
      free_wait_in = free_wait_ff;
      op_in = op_ff; dev_in = dev_ff; blk_in = blk_ff; bi_in = bi_ff;
      all_in = all_ff; dly_in = dly_ff; asy_in = asy_ff; ioe_in = ioe_ff;
      cnt_in = cnt_ff; cur_in = cur_ff;
      cmp_vld_in = 1'b0; cmp_idx_in = cmp_idx_ff;
      hit_in = hit_ff; hit_idx_in = hit_idx_ff;
      st_in = st_ff; idx_in = idx_ff; dv_in = dv_ff; wb_in = wb_ff;
      wf_in = wf_ff; er_in = er_ff;
      rd_addr = cnt_ff[IW-1:0];
      tag_we = 1'b0; tag_waddr = '0; tag_wdev = '0; tag_wblk = '0;
      bi = bi_ff[IW-1:0];
      h = '0; p = '0; n = '0; t = '0; f = '0; tape = 1'b0; rel = 1'b0;
      claim = 1'b0; ci = '0; emaj = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in = req.operation; dev_in = req.device; blk_in = req.block_number;
               bi_in = req.buffer_index; all_in = req.all_devices;
               dly_in = req.delayed; asy_in = req.async; ioe_in = req.io_error;
               cnt_in = '0; hit_in = 1'b0; cur_in = next_ff[ANCHOR];
               st_in = ST_BAD; idx_in = '0; dv_in = 1'b0; wb_in = 1'b0;
               wf_in = 1'b0; er_in = 1'b0;
               if (req.operation == OP_GET_BLOCK) begin
                  state_in = S_SCAN;
               end else if (req.operation == OP_FLUSH) begin
                  state_in = S_WALK;
                  cnt_in = '0;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_SCAN: begin
            if (cmp_match && !hit_ff) begin
               hit_in = 1'b1;
               hit_idx_in = cmp_idx_ff;
            end
            if (cnt_ff < (IW+1)'(BUFFER_COUNT)) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = cnt_ff[IW-1:0];
               cnt_in = cnt_ff + 1'b1;
            end else if (!cmp_vld_ff) begin
               state_in = S_EXEC;
            end
         end
         S_WALK: begin
            h = cur_ff[IW-1:0];
            rd_addr = h;
            if (cur_ff >= ANCHOR || cnt_ff >= (IW+1)'(BUFFER_COUNT)) begin
               st_in = ST_NO_FLUSH;
               state_in = S_OUT;
            end else if (!cmp_vld_ff) begin
               cmp_vld_in = 1'b1;
            end else if (((flags_ff[h] & FL_DELWRI) != '0) &&
                         (all_ff || (assigned_ff[h] && rd_dev_ff == dev_ff))) begin
               p = prev_ff[h]; n = next_ff[h];
               next_in[p] = n; prev_in[n] = p;
               flags_in[h] = write_flags(flags_ff[h] | FL_BUSY, 1'b1);
               idx_in = 4'(h);
               st_in = ST_FLUSHED;
               state_in = S_OUT;
            end else begin
               cur_in = next_ff[h];
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_EXEC: begin
            state_in = S_OUT;
            if (op_ff == OP_GET_BLOCK || op_ff == OP_GET_EMPTY) begin
               if (op_ff == OP_GET_BLOCK && major_bad) begin
                  st_in = ST_BAD;
               end else if (op_ff == OP_GET_BLOCK && hit_ff) begin
                  idx_in = 4'(hit_idx_ff);
                  if ((flags_ff[hit_idx_ff] & FL_BUSY) != '0) begin
                     flags_in[hit_idx_ff] = flags_ff[hit_idx_ff] | FL_WANTED;
                     st_in = ST_WAIT_BUSY;
                  end else begin
                     claim = 1'b1; ci = hit_idx_ff;
                     st_in = ST_HIT;
                     dv_in = (flags_ff[hit_idx_ff] & FL_DONE) != '0;
                     er_in = (flags_ff[hit_idx_ff] & FL_ERROR) != '0;
                  end
               end else if (next_ff[ANCHOR] >= ANCHOR) begin
                  free_wait_in = 1'b1;
                  st_in = ST_WAIT_FREE;
               end else begin
                  ci = next_ff[ANCHOR][IW-1:0];
                  claim = 1'b1;
                  idx_in = 4'(ci);
                  if ((flags_ff[ci] & FL_DELWRI) != '0) begin
                     st_in = ST_VICTIM;
                  end else begin
                     st_in = ST_ASSIGNED;
                     assigned_in[ci] = (op_ff == OP_GET_BLOCK);
                     tag_we = 1'b1; tag_waddr = ci;
                     tag_wdev = (op_ff == OP_GET_BLOCK) ? dev_ff : '0;
                     tag_wblk = (op_ff == OP_GET_BLOCK) ? blk_ff : '0;
                  end
               end
               if (claim) begin
                  p = prev_ff[ci]; n = next_ff[ci];
                  next_in[p] = n; prev_in[n] = p;
                  f = flags_ff[ci] | FL_BUSY;
                  if (st_in == ST_VICTIM) begin
                     f = write_flags(f, 1'b1);
                  end else if (st_in == ST_ASSIGNED) begin
                     f = FL_BUSY;
                  end
                  flags_in[ci] = f;
               end
            end else if (op_ff >= OP_RELEASE && op_ff <= OP_IO_DONE &&
                         (32'(bi_ff) < BUFFER_COUNT) &&
                         (flags_ff[bi] & FL_BUSY) != '0) begin
               idx_in = bi_ff;
               f = flags_ff[bi];
               emaj = rd_dev_ff[15:8];
               tape = assigned_ff[bi] && (emaj < 8'd8) && tape_mask_ff[emaj[2:0]];
               case (op_ff)
                  OP_RELEASE: begin
                     er_in = (f & FL_ERROR) != '0;
                     if (dly_ff && tape) begin
                        f = write_flags(f, 1'b1);
                        er_in = 1'b0;
                        st_in = ST_WR_START;
                     end else begin
                        if (dly_ff) begin
                           f = f | FL_DELWRI | FL_DONE;
                        end
                        rel = 1'b1;
                        st_in = ST_RELEASED;
                     end
                  end
                  OP_START_RD: begin
                     f = (f & ~(FL_DONE | FL_ERROR)) | FL_READ;
                     st_in = ST_RD_START;
                  end
                  OP_START_WR: begin
                     f = write_flags(f, asy_ff);
                     st_in = ST_WR_START;
                  end
                  default: begin
                     f = f | FL_DONE;
                     if (ioe_ff) begin
                        f = f | FL_ERROR;
                     end
                     er_in = (f & FL_ERROR) != '0;
                     if ((f & FL_ASYNC) != '0) begin
                        rel = 1'b1;
                     end else begin
                        f = f & ~FL_WANTED;
                        wb_in = 1'b1;
                     end
                     st_in = ST_DONE;
                  end
               endcase
               if (rel) begin
                  wb_in = (f & FL_WANTED) != '0;
                  wf_in = free_wait_ff;
                  free_wait_in = 1'b0;
                  if ((f & FL_ERROR) != '0) begin
                     assigned_in[bi] = 1'b0;
                  end
                  t = ((f & FL_AGE) != '0) ? ANCHOR : prev_ff[ANCHOR];
                  n = next_ff[t];
                  next_in[LW'(bi)] = n;
                  prev_in[LW'(bi)] = t;
                  prev_in[n] = LW'(bi);
                  next_in[t] = LW'(bi);
                  f = f & ~(FL_WANTED | FL_BUSY | FL_ASYNC | FL_AGE);
               end
               flags_in[bi] = f;
            end
         end
         S_OUT: begin
            if (rsp_fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_IDLE || (state_ff == S_EXEC && op_ff != OP_GET_BLOCK)) begin
         rd_addr = (state_ff == S_IDLE) ? req.buffer_index[IW-1:0] : bi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dev_count_ff <= 4'd8;
         tape_mask_ff <= '0;
         assigned_ff <= '0;
         free_wait_ff <= 1'b0;
         cmp_vld_ff <= 1'b0;
         for (int k = 0; k < BUFFER_COUNT; k++) begin
            flags_ff[k] <= '0;
            next_ff[k] <= LW'(k + 1);
            prev_ff[k] <= (k == 0) ? ANCHOR : LW'(k - 1);
         end
         next_ff[BUFFER_COUNT] <= '0;
         prev_ff[BUFFER_COUNT] <= LAST;
      end else begin
         state_ff <= state_in;
         dev_count_ff <= dev_count_in;
         tape_mask_ff <= tape_mask_in;
         assigned_ff <= assigned_in;
         free_wait_ff <= free_wait_in;
         cmp_vld_ff <= cmp_vld_in;
         flags_ff <= flags_in;
         next_ff <= next_in;
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; dev_ff <= dev_in; blk_ff <= blk_in; bi_ff <= bi_in;
      all_ff <= all_in; dly_ff <= dly_in; asy_ff <= asy_in; ioe_ff <= ioe_in;
      cnt_ff <= cnt_in; cur_ff <= cur_in; cmp_idx_ff <= cmp_idx_in;
      hit_ff <= hit_in; hit_idx_ff <= hit_idx_in;
      st_ff <= st_in; idx_ff <= idx_in; dv_ff <= dv_in; wb_ff <= wb_in;
      wf_ff <= wf_in; er_ff <= er_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request taken while result pending");

   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid)
      else $error("result dropped under stall");

   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == ST_HIT) |-> (rsp.wake_buffer == 1'b0))
      else $error("hit issued a wakeup");

   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !rsp.valid)
      else $error("result before work");

endmodule
